// ----- hw/rtl/sews_pkg.sv -----
// Shared types, codes and constants for the SPI EEPROM word sequencer.
package sews_pkg;

    // Stream word widths
    localparam int unsigned S_TDATA_W  = 56;
    localparam int unsigned S_TUSER_W  = 3;
    localparam int unsigned M_TDATA_W  = 48;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 8;

    // Request kinds carried on s_tuser
    localparam logic [2:0] REQ_READ16  = 3'd0;
    localparam logic [2:0] REQ_READ32  = 3'd1;
    localparam logic [2:0] REQ_WRITE16 = 3'd2;
    localparam logic [2:0] REQ_WRITE32 = 3'd3;
    localparam logic [2:0] REQ_XFER    = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OP_READ      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OP_WRITE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OP_WREN      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OP_WRDI      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OP_RDSR      = 3'd4;

    // Opcode reset values
    localparam logic [7:0] OP_READ_RST  = 8'h03;
    localparam logic [7:0] OP_WRITE_RST = 8'h02;
    localparam logic [7:0] OP_WREN_RST  = 8'h06;
    localparam logic [7:0] OP_WRDI_RST  = 8'h04;
    localparam logic [7:0] OP_RDSR_RST  = 8'h05;

    // Status register busy bit
    localparam int unsigned STATUS_WIP_BIT = 0;

    // Sequencer phases
    typedef enum logic [4:0] {
        PH_IDLE      = 5'd0,
        PH_POLLA_CMD = 5'd1,
        PH_POLLA_DAT = 5'd2,
        PH_WREN      = 5'd3,
        PH_POLLB_CMD = 5'd4,
        PH_POLLB_DAT = 5'd5,
        PH_WR_CMD    = 5'd6,
        PH_WR_AHI    = 5'd7,
        PH_WR_ALO    = 5'd8,
        PH_WR_DATA   = 5'd9,
        PH_ST3_CMD   = 5'd10,
        PH_ST3_DAT   = 5'd11,
        PH_WRDI      = 5'd12,
        PH_ST4_CMD   = 5'd13,
        PH_ST4_DAT   = 5'd14,
        PH_RD_CMD    = 5'd15,
        PH_RD_AHI    = 5'd16,
        PH_RD_ALO    = 5'd17,
        PH_RD_DATA   = 5'd18
    } phase_t;

endpackage

// ----- hw/rtl/spi_eeprom_word_sequencer.sv -----
// Top level of the SPI EEPROM word sequencer: input stage, phase logic, result stage.
//
// Usage
//   The slave stream takes one word per event: a request (read16, read32, write16,
//   write32, kind on s_tuser) or the report that the byte in flight has finished
//   shifting (kind 4, with the received byte in s_tdata). Every accepted word gives
//   exactly one result word on the master stream: the next byte to shift out with
//   its chip select level, the write protect level, and on completion the done flag
//   with the assembled big-endian read data. A request arriving mid-sequence is
//   dropped and answered with busy_reject. Opcodes are set through the cfg_ write
//   port; the user must do so only while idle, as the block does not enforce it.
// Pipeline and throughput
//   An accepted word is registered in the input stage, then processed by the phase
//   logic and registered with the phase update in the result stage, which drives
//   m_tvalid. One word per cycle is sustained while m_tready is high.
// Reset
//   aresetn (synchronous, active low) empties both stages, returns the sequencer to
//   idle with write protect asserted, and restores the default opcodes.
// Stall
//   While m_tready is low the result word holds; one further word is taken into the
//   input stage, after which s_tready drops until the result is taken.
module spi_eeprom_word_sequencer (
    input  logic                                aclk,
    input  logic                                aresetn,
    // s_tdata: slot_index[13:0], write_value[45:14], rx_byte[53:46], zero pad[55:54]
    input  logic [sews_pkg::S_TDATA_W-1:0]      s_tdata,
    // s_tuser: req_type[2:0]
    input  logic [sews_pkg::S_TUSER_W-1:0]      s_tuser,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // m_tdata: tx_valid[0], tx_byte[8:1], select_active[9], protect_released[10],
    //          read_value[42:11], done_res[43], busy_reject[44], zero pad[47:45]
    output logic [sews_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_wr_en,
    input  logic [sews_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sews_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import sews_pkg::*;

    // Opcode registers
    logic [7:0]  op_read_reg;
    logic [7:0]  op_write_reg;
    logic [7:0]  op_wren_reg;
    logic [7:0]  op_wrdi_reg;
    logic [7:0]  op_rdsr_reg;

    // Input stage
    logic        in_valid_reg;
    logic [2:0]  in_req_reg;
    logic [13:0] in_slot_reg;
    logic [31:0] in_wv_reg;
    logic [7:0]  in_rx_reg;

    // Sequencer state
    phase_t      phase_reg,        phase_next;
    logic [2:0]  byte_count_reg,   byte_count_next;
    logic [1:0]  request_kind_reg, request_kind_next;
    logic [15:0] byte_address_reg, byte_address_next;
    logic [31:0] data_shift_reg,   data_shift_next;
    logic        protect_level_reg, protect_level_next;

    // Result stage
    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;

    logic        fire;
    logic        s_accept;
    logic        tx;
    logic        done;
    logic        reject;
    logic [31:0] rd_value;
    logic [7:0]  tx_byte;

    // Process the staged word when the result stage is free or draining
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Configuration writes; indexes past the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_read_reg  <= OP_READ_RST;
            op_write_reg <= OP_WRITE_RST;
            op_wren_reg  <= OP_WREN_RST;
            op_wrdi_reg  <= OP_WRDI_RST;
            op_rdsr_reg  <= OP_RDSR_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_OP_READ:  op_read_reg  <= cfg_wdata;
                CFG_OP_WRITE: op_write_reg <= cfg_wdata;
                CFG_OP_WREN:  op_wren_reg  <= cfg_wdata;
                CFG_OP_WRDI:  op_wrdi_reg  <= cfg_wdata;
                CFG_OP_RDSR:  op_rdsr_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Capture the incoming word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= s_accept || (in_valid_reg && !fire);
        end
        if (s_accept) begin
            in_req_reg  <= s_tuser;
            in_slot_reg <= s_tdata[13:0];
            in_wv_reg   <= s_tdata[45:14];
            in_rx_reg   <= s_tdata[53:46];
        end
    end

    // Next phase, shifts and result fields
    always_comb begin
        phase_next         = phase_reg;
        byte_count_next    = byte_count_reg;
        request_kind_next  = request_kind_reg;
        byte_address_next  = byte_address_reg;
        data_shift_next    = data_shift_reg;
        protect_level_next = protect_level_reg;
        tx       = 1'b0;
        done     = 1'b0;
        reject   = 1'b0;
        rd_value = 32'd0;

        if (!in_req_reg[2]) begin
            // New request: start only from idle
            if (phase_reg != PH_IDLE) begin
                reject = 1'b1;
            end else begin
                request_kind_next = in_req_reg[1:0];
                byte_address_next = {in_slot_reg, 2'b00};
                byte_count_next   = in_req_reg[0] ? 3'd4 : 3'd2;
                if (in_req_reg[1]) begin
                    data_shift_next    = in_req_reg[0] ? in_wv_reg : {in_wv_reg[15:0], 16'd0};
                    protect_level_next = 1'b0;
                end else begin
                    data_shift_next = 32'd0;
                end
                phase_next = PH_POLLA_CMD;
                tx         = 1'b1;
            end
        end else if (in_req_reg == REQ_XFER && phase_reg != PH_IDLE) begin
            // Byte finished: advance the sequence
            unique case (phase_reg)
                PH_POLLA_CMD: phase_next = PH_POLLA_DAT;
                PH_POLLA_DAT: begin
                    if (in_rx_reg[STATUS_WIP_BIT]) begin
                        phase_next = PH_POLLA_CMD;
                    end else begin
                        phase_next = request_kind_reg[1] ? PH_WREN : PH_RD_CMD;
                    end
                end
                PH_WREN:      phase_next = PH_POLLB_CMD;
                PH_POLLB_CMD: phase_next = PH_POLLB_DAT;
                PH_POLLB_DAT: begin
                    phase_next = in_rx_reg[STATUS_WIP_BIT] ? PH_POLLB_CMD : PH_WR_CMD;
                end
                PH_WR_CMD:    phase_next = PH_WR_AHI;
                PH_WR_AHI:    phase_next = PH_WR_ALO;
                PH_WR_ALO:    phase_next = PH_WR_DATA;
                PH_WR_DATA: begin
                    data_shift_next = {data_shift_reg[23:0], 8'd0};
                    byte_count_next = byte_count_reg - 3'd1;
                    phase_next      = (byte_count_next == 3'd0) ? PH_ST3_CMD : PH_WR_DATA;
                end
                PH_ST3_CMD:   phase_next = PH_ST3_DAT;
                PH_ST3_DAT:   phase_next = PH_WRDI;
                PH_WRDI: begin
                    protect_level_next = 1'b1;
                    phase_next         = PH_ST4_CMD;
                end
                PH_ST4_CMD:   phase_next = PH_ST4_DAT;
                PH_RD_CMD:    phase_next = PH_RD_AHI;
                PH_RD_AHI:    phase_next = PH_RD_ALO;
                PH_RD_ALO:    phase_next = PH_RD_DATA;
                PH_RD_DATA: begin
                    data_shift_next = {data_shift_reg[23:0], in_rx_reg};
                    byte_count_next = byte_count_reg - 3'd1;
                    phase_next      = (byte_count_next == 3'd0) ? PH_IDLE : PH_RD_DATA;
                end
                default:      phase_next = PH_IDLE;
            endcase

            if (phase_next == PH_IDLE) begin
                done = 1'b1;
                if (phase_reg == PH_RD_DATA) begin
                    rd_value = data_shift_next;
                end
            end else begin
                tx = 1'b1;
            end
        end

        // Byte to shift out for the phase entered
        tx_byte = 8'd0;
        if (tx) begin
            unique case (phase_next)
                PH_POLLA_CMD, PH_POLLB_CMD, PH_ST3_CMD, PH_ST4_CMD: tx_byte = op_rdsr_reg;
                PH_WREN:              tx_byte = op_wren_reg;
                PH_WR_CMD:            tx_byte = op_write_reg;
                PH_WRDI:              tx_byte = op_wrdi_reg;
                PH_RD_CMD:            tx_byte = op_read_reg;
                PH_WR_AHI, PH_RD_AHI: tx_byte = byte_address_next[15:8];
                PH_WR_ALO, PH_RD_ALO: tx_byte = byte_address_next[7:0];
                PH_WR_DATA:           tx_byte = data_shift_next[31:24];
                default:              tx_byte = 8'd0;
            endcase
        end
    end

    // Sequencer state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_IDLE;
            byte_count_reg    <= 3'd0;
            request_kind_reg  <= 2'd0;
            byte_address_reg  <= 16'd0;
            data_shift_reg    <= 32'd0;
            protect_level_reg <= 1'b1;
        end else if (fire) begin
            phase_reg         <= phase_next;
            byte_count_reg    <= byte_count_next;
            request_kind_reg  <= request_kind_next;
            byte_address_reg  <= byte_address_next;
            data_shift_reg    <= data_shift_next;
            protect_level_reg <= protect_level_next;
        end
    end

    // Result stage: load on fire, hold while stalled
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= fire || (out_valid_reg && !m_tready);
        end
        if (fire) begin
            out_data_reg <= {3'd0, reject, done, rd_value, !protect_level_next,
                             tx, tx_byte, tx};
        end
    end

endmodule

// ----- hw/rtl/sews_checker.sv -----
// Port-level checker for the SPI EEPROM word sequencer, bound to the top level.
module sews_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [sews_pkg::M_TDATA_W-1:0]  m_tdata
);
    import sews_pkg::*;

    // A stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // Reset empties the result stage
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Chip select follows the byte-out flag
    a_select: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[9] == m_tdata[0])
        else $error("select level differs from tx_valid");

    // A finished request sends no further byte
    a_done_tx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[43] |-> !m_tdata[0] && m_tdata[8:1] == 8'd0)
        else $error("byte sent with done");

    // A rejected request neither sends nor completes nor returns data
    a_reject: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[44] |-> !m_tdata[0] && !m_tdata[43] && m_tdata[42:11] == 32'd0)
        else $error("rejected request produced activity");

endmodule

bind spi_eeprom_word_sequencer sews_checker u_sews_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- tb/sews_check.sv -----
// Stream watcher for the SPI EEPROM word sequencer: predicts each result word and compares it.
module sews_check (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [sews_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [sews_pkg::S_TUSER_W-1:0]  s_tuser,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [sews_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic                            cfg_wr_en,
    input  logic [sews_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sews_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                              words_outstanding,
    output int                              mismatches
);
    timeunit 1ns;
    timeprecision 1ps;
    import sews_pkg::*;

    // Result word layout, lowest bit last
    typedef struct packed {
        logic        busy_reject;
        logic        done_res;
        logic [31:0] read_value;
        logic        protect_released;
        logic        select_active;
        logic [7:0]  tx_byte;
        logic        tx_valid;
    } seq_reply_t;

    // Opcode copies
    logic [7:0]  op_rd, op_wr, op_wren, op_wrdi, op_rdsr;

    // Sequencer state copy
    phase_t      phase;
    logic [2:0]  byte_count;
    logic [1:0]  req_kind;
    logic [15:0] byte_addr;
    logic [31:0] shift_reg;
    logic        wp_released;

    seq_reply_t  replies_due[$];
    int          errors = 0;

    // Byte to shift out while sitting in a given phase
    function automatic logic [7:0] byte_for_phase(phase_t p);
        case (p)
            PH_POLLA_CMD, PH_POLLB_CMD, PH_ST3_CMD, PH_ST4_CMD: return op_rdsr;
            PH_WREN:               return op_wren;
            PH_WR_CMD:             return op_wr;
            PH_WRDI:               return op_wrdi;
            PH_RD_CMD:             return op_rd;
            PH_WR_AHI, PH_RD_AHI:  return byte_addr[15:8];
            PH_WR_ALO, PH_RD_ALO:  return byte_addr[7:0];
            PH_WR_DATA:            return shift_reg[31:24];
            default:               return 8'h00;
        endcase
    endfunction

    // Advance one phase on a finished byte exchange
    function automatic phase_t phase_after(phase_t p, logic [7:0] rx);
        case (p)
            PH_POLLA_CMD: return PH_POLLA_DAT;
            PH_POLLA_DAT: begin
                if (rx[STATUS_WIP_BIT]) return PH_POLLA_CMD;
                return req_kind[1] ? PH_WREN : PH_RD_CMD;
            end
            PH_WREN:      return PH_POLLB_CMD;
            PH_POLLB_CMD: return PH_POLLB_DAT;
            PH_POLLB_DAT: return rx[STATUS_WIP_BIT] ? PH_POLLB_CMD : PH_WR_CMD;
            PH_WR_CMD:    return PH_WR_AHI;
            PH_WR_AHI:    return PH_WR_ALO;
            PH_WR_ALO:    return PH_WR_DATA;
            PH_WR_DATA: begin
                shift_reg  = shift_reg << 8;
                byte_count = byte_count - 3'd1;
                return (byte_count == 3'd0) ? PH_ST3_CMD : PH_WR_DATA;
            end
            PH_ST3_CMD:   return PH_ST3_DAT;
            PH_ST3_DAT:   return PH_WRDI;
            PH_WRDI: begin
                wp_released = 1'b0;
                return PH_ST4_CMD;
            end
            PH_ST4_CMD:   return PH_ST4_DAT;
            PH_RD_CMD:    return PH_RD_AHI;
            PH_RD_AHI:    return PH_RD_ALO;
            PH_RD_ALO:    return PH_RD_DATA;
            PH_RD_DATA: begin
                shift_reg  = {shift_reg[23:0], rx};
                byte_count = byte_count - 3'd1;
                return (byte_count == 3'd0) ? PH_IDLE : PH_RD_DATA;
            end
            default:      return PH_IDLE;
        endcase
    endfunction

    // Apply one input word to the state copy and work out its result word
    function automatic seq_reply_t step_sequencer(logic [2:0] kind, logic [13:0] slot,
                                                  logic [31:0] val, logic [7:0] rx);
        seq_reply_t r;
        phase_t     prior;
        logic       tx;
        r  = '0;
        tx = 1'b0;
        if (kind <= REQ_WRITE32) begin
            if (phase != PH_IDLE) begin
                r.busy_reject = 1'b1;
            end else begin
                req_kind   = kind[1:0];
                byte_addr  = {slot, 2'b00};
                byte_count = kind[0] ? 3'd4 : 3'd2;
                if (kind[1]) begin
                    shift_reg   = kind[0] ? val : {val[15:0], 16'h0000};
                    wp_released = 1'b1;
                end else begin
                    shift_reg = 32'h0;
                end
                phase = PH_POLLA_CMD;
                tx    = 1'b1;
            end
        end else if (kind == REQ_XFER && phase != PH_IDLE) begin
            prior = phase;
            phase = phase_after(phase, rx);
            if (phase == PH_IDLE) begin
                r.done_res = 1'b1;
                if (prior == PH_RD_DATA) r.read_value = shift_reg;
            end else begin
                tx = 1'b1;
            end
        end
        r.tx_valid         = tx;
        r.tx_byte          = tx ? byte_for_phase(phase) : 8'h00;
        r.select_active    = tx;
        r.protect_released = wp_released;
        return r;
    endfunction

    task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
            errors++;
        end
    endtask

    // Watch both channels and the register port
    always @(posedge aclk) begin
        seq_reply_t want, got;
        if (!aresetn) begin
            op_rd       = OP_READ_RST;
            op_wr       = OP_WRITE_RST;
            op_wren     = OP_WREN_RST;
            op_wrdi     = OP_WRDI_RST;
            op_rdsr     = OP_RDSR_RST;
            phase       = PH_IDLE;
            byte_count  = 3'd0;
            req_kind    = 2'd0;
            byte_addr   = 16'h0;
            shift_reg   = 32'h0;
            wp_released = 1'b0;
            replies_due.delete();
        end else begin
            // Compare the result word against the oldest prediction
            if (m_tvalid && m_tready) begin
                got = m_tdata[44:0];
                if (replies_due.size() == 0) begin
                    $display("%0t: result word %0h arrived with none outstanding",
                             $time, m_tdata);
                    errors++;
                end else begin
                    want = replies_due.pop_front();
                    compare_field("tx_valid", 32'(want.tx_valid), 32'(got.tx_valid));
                    compare_field("tx_byte", 32'(want.tx_byte), 32'(got.tx_byte));
                    compare_field("select_active", 32'(want.select_active),
                                  32'(got.select_active));
                    compare_field("protect_released", 32'(want.protect_released),
                                  32'(got.protect_released));
                    compare_field("read_value", want.read_value, got.read_value);
                    compare_field("done_res", 32'(want.done_res), 32'(got.done_res));
                    compare_field("busy_reject", 32'(want.busy_reject),
                                  32'(got.busy_reject));
                    compare_field("pad", 32'h0, 32'(m_tdata[47:45]));
                end
            end
            // Track opcode writes; higher indexes are dropped
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_OP_READ:  op_rd   = cfg_wdata;
                    CFG_OP_WRITE: op_wr   = cfg_wdata;
                    CFG_OP_WREN:  op_wren = cfg_wdata;
                    CFG_OP_WRDI:  op_wrdi = cfg_wdata;
                    CFG_OP_RDSR:  op_rdsr = cfg_wdata;
                    default: ;
                endcase
            end
            // Predict the result of an accepted input word
            if (s_tvalid && s_tready)
                replies_due.push_back(step_sequencer(s_tuser, s_tdata[13:0],
                                                     s_tdata[45:14], s_tdata[53:46]));
        end
        words_outstanding <= replies_due.size();
        mismatches        <= errors;
    end

endmodule

// ----- tb/tb_top.sv -----
// Top of the SPI EEPROM word sequencer testbench: clock, reset, stimulus and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import sews_pkg::*;

    // Highest request code on the 3-bit kind field
    localparam logic [2:0] REQ_LAST_CODE = 3'd7;
    localparam int PHASE_WORDS = 425;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [S_TUSER_W-1:0]  s_tuser   = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int words_outstanding;
    int mismatches;
    int tx_idle_pct = 31;
    int rx_idle_pct = 86;
    int noise_pct   = 0;
    int seq_words   = 0;
    logic hold_rx   = 1'b0;

    spi_eeprom_word_sequencer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    sews_check u_check (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_tdata           (s_tdata),
        .s_tuser           (s_tuser),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .m_tdata           (m_tdata),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .words_outstanding (words_outstanding),
        .mismatches        (mismatches)
    );

    always #6 aclk = ~aclk;

    // Receiver: take result words at random, or hold off entirely
    always @(posedge aclk) begin
        m_tready <= !hold_rx && ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Hold the result side for a long stretch so the block backs up
    initial begin
        wait (seq_words >= 200);
        @(posedge aclk);
        hold_rx <= 1'b1;
        repeat (400) @(posedge aclk);
        hold_rx <= 1'b0;
    end

    // Offer one word, idling at random first, and wait for its handshake
    task automatic push_word(logic [2:0] kind, logic [13:0] slot, logic [31:0] val,
                             logic [7:0] rx);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {2'b00, rx, val, slot};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Completed byte exchange, with a stray request or unused code slipped in now and then
    task automatic push_xfer(logic [7:0] rx);
        if ($urandom_range(0, 99) < noise_pct) begin
            if ($urandom_range(0, 1))
                push_word(3'($urandom_range(REQ_READ16, REQ_WRITE32)), 14'($urandom),
                          $urandom, 8'($urandom));
            else
                push_word(3'($urandom_range(REQ_XFER + 1, REQ_LAST_CODE)), 14'($urandom),
                          $urandom, 8'($urandom));
        end
        push_word(REQ_XFER, 14'($urandom), $urandom, rx);
        seq_words++;
    endtask

    // Status poll: busy_reads reads with the busy bit set, then one clear
    task automatic poll_status(int busy_reads);
        for (int i = 0; i <= busy_reads; i++) begin
            push_xfer(8'($urandom));
            push_xfer({7'($urandom), i < busy_reads});
        end
    endtask

    // One well-formed request and every byte exchange it needs
    task automatic run_operation(logic [2:0] kind, logic [13:0] slot, logic [31:0] val,
                                 int busy_a, int busy_b, bit busy_probe);
        int data_bytes;
        data_bytes = kind[0] ? 4 : 2;
        push_word(kind, slot, val, 8'($urandom));
        seq_words++;
        if (busy_probe)
            push_word(3'($urandom_range(REQ_READ16, REQ_WRITE32)), 14'($urandom),
                      $urandom, 8'($urandom));
        poll_status(busy_a);
        if (kind[1]) begin
            push_xfer(8'($urandom));
            poll_status(busy_b);
            // opcode, address and data, then status, write disable, status
            repeat (3 + data_bytes) push_xfer(8'($urandom));
            repeat (5) push_xfer(8'($urandom));
        end else begin
            repeat (3 + data_bytes) push_xfer(8'($urandom));
        end
    endtask

    // Drop valid and wait until every outstanding result word has come back
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (words_outstanding != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Load all opcodes: 1 all zeros, 2 all ones, else random plus a write to an unused index
    task automatic write_opcodes(int mode);
        for (int i = CFG_OP_READ; i <= CFG_OP_RDSR; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_wdata <= (mode == 1) ? 8'h00 : (mode == 2) ? 8'hff : 8'($urandom);
            @(posedge aclk);
        end
        if (mode > 2) begin
            cfg_index <= CFG_IDX_W'(CFG_OP_RDSR + $urandom_range(1, 3));
            cfg_wdata <= 8'($urandom);
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    function automatic int busy_count();
        return ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 3);
    endfunction

    // Stimulus
    initial begin
        int          target;
        logic [13:0] slot;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: idle completion, unused code, busy request, full write with a repeated poll
        push_word(REQ_XFER, 14'h3fff, 32'hffff_ffff, 8'hff);
        push_word(REQ_LAST_CODE, 14'h3fff, 32'hffff_ffff, 8'hff);
        run_operation(REQ_READ16, 14'h3fff, 32'hffff_ffff, 0, 0, 1'b1);
        run_operation(REQ_WRITE16, 14'h0000, 32'h0001_ffff, 0, 1, 1'b0);
        settle();

        // Random phases, one opcode setting each
        noise_pct = 6;
        for (int p = 0; p < 4; p++) begin
            if (p > 0) write_opcodes(p);
            target = seq_words + PHASE_WORDS;
            while (seq_words < target) begin
                if (seq_words < 580) begin
                    tx_idle_pct = 31;
                    rx_idle_pct <= 86;
                end else if (seq_words < 1160) begin
                    tx_idle_pct = 86;
                    rx_idle_pct <= 31;
                end else begin
                    tx_idle_pct = 0;
                    rx_idle_pct <= 0;
                end
                case ($urandom_range(0, 19))
                    0:       slot = 14'h0000;
                    1:       slot = 14'h3fff;
                    default: slot = 14'($urandom);
                endcase
                run_operation(3'($urandom_range(REQ_READ16, REQ_WRITE32)), slot, $urandom,
                              busy_count(), busy_count(), 1'b0);
                // Stray words while idle
                if ($urandom_range(0, 9) == 0)
                    push_word(REQ_XFER, 14'($urandom), $urandom, 8'($urandom));
                if ($urandom_range(0, 19) == 0)
                    push_word(3'($urandom_range(REQ_XFER + 1, REQ_LAST_CODE)), 14'($urandom),
                              $urandom, 8'($urandom));
            end
            settle();
        end

        repeat (12) @(posedge aclk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Run limit, far beyond the slowest correct run
    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
